[src/klm_pkg.sv]
// Shared constants, command codes and controller/datapath structs for the ledger merge.
`timescale 1ns / 1ps
package klm_pkg;

  localparam int LEDGER_DEPTH_DEF  = 16;
  localparam int PROTECT_DEPTH_DEF = 16;
  localparam int MAX_RESULTS       = 32;
  localparam int CNT_W             = 6;

  localparam logic [2:0] CMD_LOAD_LEFT     = 3'd0;
  localparam logic [2:0] CMD_LOAD_RIGHT    = 3'd1;
  localparam logic [2:0] CMD_PROTECT_LEFT  = 3'd2;
  localparam logic [2:0] CMD_PROTECT_RIGHT = 3'd3;
  localparam logic [2:0] CMD_MERGE         = 3'd4;

  localparam logic [0:0] REG_OUT_CAPACITY = 1'd0;

  typedef struct packed {
    logic [15:0]        batch;
    logic [15:0]        cell_idx;
    logic signed [31:0] fitness;
    logic [63:0]        payload;
    logic               from_right;
  } entry_t;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic run_clr;
    logic phase_r;
    logic oi_clr;
    logic oi_inc;
    logic si_clr;
    logic si_inc;
    logic p_clr;
    logic p_inc;
    logic pab_clr;
    logic set_pa;
    logic set_pb;
    logic nc_inc;
    logic win_left;
    logic win_right;
    logic win_decide;
    logic emit;
    logic finish;
  } ctl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic oi_end;
    logic si_end;
    logic key_match;
    logic p_end_l;
    logic p_end_r;
    logic hit_l;
    logic hit_r;
    logic emit_ok;
    logic out_free;
  } ctl_stat_t;

endpackage

[src/keyed_ledger_merge_with_protection_unit.sv]
// Top level of the keyed ledger merge with one-sided protection.
`timescale 1ns / 1ps
// Channel  | Dir | Signals                               | Content
// s_*      | in  | s_tvalid s_tready s_tdata s_tuser     | load / protect / merge requests
// m_*      | out | m_tvalid m_tready m_tdata m_tuser m_tlast | merged entries, tallies on last
// apb      | in  | psel penable pwrite paddr pwdata prdata pready | out_capacity register
//
// Sequence: load and protect requests are taken while idle. A merge is accepted, then each
//   left entry scans the right ledger and is emitted; on a key match the left and then the right
//   protection list are first read to a hit or to their end and the contest is decided. Then each
//   right entry scans the left ledger and is emitted if unmatched; then the merge closes.
// Reset: synchronous, active high; clears counts and handshake state, not the stores.
// Stalls: an emit waits only while the output register and the pending result are full.
module keyed_ledger_merge_with_protection_unit #(
  parameter int LEDGER_DEPTH  = klm_pkg::LEDGER_DEPTH_DEF,
  parameter int PROTECT_DEPTH = klm_pkg::PROTECT_DEPTH_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // [15:0] batch, [31:16] cell_index, [63:32] fitness, [127:64] payload,
  // [128] protect_flag, [135:129] zero
  input  logic [135:0] s_tdata,
  // [2:0] command
  input  logic [2:0]   s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // [15:0] out_batch, [31:16] out_cell_index, [63:32] out_fitness,
  // [127:64] out_payload, [133:128] left taken, [139:134] right taken,
  // [145:140] conflicts, [151:146] protection wins, [157:152] dropped, [159:158] zero
  output logic [159:0] m_tdata,
  // [0] entry_valid, [1] from_right
  output logic [1:0]   m_tuser,
  output logic         m_tlast,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [1:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  klm_pkg::ctl_cmd_t  cmd;
  klm_pkg::ctl_stat_t stat;
  klm_pkg::entry_t    out_entry;
  logic                        out_entry_valid;
  logic [klm_pkg::CNT_W-1:0]   capacity;
  logic [klm_pkg::CNT_W-1:0]   kl, kr, nc, pw, nd;

  // single config register; writes need paddr[1] clear, reads return it at every address
  assign pready = 1'b1;
  assign prdata = {{(32 - klm_pkg::CNT_W){1'b0}}, capacity};

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= klm_pkg::CNT_W'(klm_pkg::MAX_RESULTS);
    end else if (psel && penable && pwrite && pready &&
                 (paddr[1] == klm_pkg::REG_OUT_CAPACITY)) begin
      capacity <= pwdata[klm_pkg::CNT_W-1:0];
    end
  end

  klm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_command(s_tuser),
    .in_ready  (s_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  klm_datapath #(
    .LEDGER_DEPTH (LEDGER_DEPTH),
    .PROTECT_DEPTH(PROTECT_DEPTH)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .stat            (stat),
    .in_command      (s_tuser),
    .in_batch        (s_tdata[15:0]),
    .in_cell         (s_tdata[31:16]),
    .in_fitness      (s_tdata[63:32]),
    .in_payload      (s_tdata[127:64]),
    .in_flag         (s_tdata[128]),
    .capacity        (capacity),
    .out_ready       (m_tready),
    .out_valid       (m_tvalid),
    .out_entry_valid (out_entry_valid),
    .out_entry       (out_entry),
    .out_last        (m_tlast),
    .out_left_taken  (kl),
    .out_right_taken (kr),
    .out_conflicts   (nc),
    .out_shield_wins (pw),
    .out_dropped     (nd)
  );

  assign m_tdata = {2'b00, nd, pw, nc, kr, kl, out_entry.payload,
                    out_entry.fitness, out_entry.cell_idx, out_entry.batch};
  assign m_tuser = {out_entry.from_right, out_entry_valid};

endmodule

[src/klm_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module klm_ram #(
  parameter int WIDTH = 17,
  parameter int DEPTH = 16
) (
  input  logic                                 clk,
  input  logic                                 we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                     wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[src/klm_ctrl.sv]
// Merge sequencer: walks ledgers and protection lists through the datapath.
`timescale 1ns / 1ps
module klm_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic [2:0]          in_command,
  output logic                in_ready,
  input  klm_pkg::ctl_stat_t  stat,
  output klm_pkg::ctl_cmd_t   cmd
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_L_TOP  = 4'd1;
  localparam logic [3:0] S_L_SCAN = 4'd2;
  localparam logic [3:0] S_LP_RD  = 4'd3;
  localparam logic [3:0] S_LP_CK  = 4'd4;
  localparam logic [3:0] S_RP_RD  = 4'd5;
  localparam logic [3:0] S_RP_CK  = 4'd6;
  localparam logic [3:0] S_DECIDE = 4'd7;
  localparam logic [3:0] S_EMIT   = 4'd8;
  localparam logic [3:0] S_R_TOP  = 4'd9;
  localparam logic [3:0] S_R_SCAN = 4'd10;
  localparam logic [3:0] S_FIN    = 4'd11;

  logic [3:0] state, state_next;
  logic       phase_r, phase_r_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      phase_r <= 1'b0;
    end else begin
      state   <= state_next;
      phase_r <= phase_r_next;
    end
  end

  always_comb begin
    state_next   = state;
    phase_r_next = phase_r;
    cmd          = '0;
    cmd.phase_r  = phase_r;
    in_ready     = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_command == klm_pkg::CMD_MERGE) begin
            cmd.run_clr  = 1'b1;
            phase_r_next = 1'b0;
            state_next   = S_L_TOP;
          end else begin
            cmd.load = 1'b1;
          end
        end
      end
      S_L_TOP: begin
        if (stat.oi_end) begin
          cmd.oi_clr   = 1'b1;
          phase_r_next = 1'b1;
          state_next   = S_R_TOP;
        end else begin
          cmd.si_clr = 1'b1;
          state_next = S_L_SCAN;
        end
      end
      S_L_SCAN: begin
        if (stat.si_end) begin
          cmd.win_left = 1'b1;
          state_next   = S_EMIT;
        end else if (stat.key_match) begin
          cmd.nc_inc  = 1'b1;
          cmd.p_clr   = 1'b1;
          cmd.pab_clr = 1'b1;
          state_next  = S_LP_RD;
        end else begin
          cmd.si_inc = 1'b1;
        end
      end
      S_LP_RD: begin
        if (stat.p_end_l) begin
          cmd.p_clr  = 1'b1;
          state_next = S_RP_RD;
        end else begin
          state_next = S_LP_CK;
        end
      end
      S_LP_CK: begin
        if (stat.hit_l) begin
          cmd.set_pa = 1'b1;
          cmd.p_clr  = 1'b1;
          state_next = S_RP_RD;
        end else begin
          cmd.p_inc  = 1'b1;
          state_next = S_LP_RD;
        end
      end
      S_RP_RD: begin
        state_next = stat.p_end_r ? S_DECIDE : S_RP_CK;
      end
      S_RP_CK: begin
        if (stat.hit_r) begin
          cmd.set_pb = 1'b1;
          state_next = S_DECIDE;
        end else begin
          cmd.p_inc  = 1'b1;
          state_next = S_RP_RD;
        end
      end
      S_DECIDE: begin
        cmd.win_decide = 1'b1;
        state_next     = S_EMIT;
      end
      S_EMIT: begin
        if (stat.emit_ok) begin
          cmd.emit   = 1'b1;
          cmd.oi_inc = 1'b1;
          state_next = phase_r ? S_R_TOP : S_L_TOP;
        end
      end
      S_R_TOP: begin
        if (stat.oi_end) begin
          state_next = S_FIN;
        end else begin
          cmd.si_clr = 1'b1;
          state_next = S_R_SCAN;
        end
      end
      S_R_SCAN: begin
        if (stat.si_end) begin
          cmd.win_right = 1'b1;
          state_next    = S_EMIT;
        end else if (stat.key_match) begin
          cmd.oi_inc = 1'b1;
          state_next = S_R_TOP;
        end else begin
          cmd.si_inc = 1'b1;
        end
      end
      S_FIN: begin
        if (stat.out_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

[src/klm_datapath.sv]
// Ledger stores, protection RAMs, scan indexes, tallies and result registers.
`timescale 1ns / 1ps
module klm_datapath #(
  parameter int LEDGER_DEPTH  = klm_pkg::LEDGER_DEPTH_DEF,
  parameter int PROTECT_DEPTH = klm_pkg::PROTECT_DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  klm_pkg::ctl_cmd_t           cmd,
  output klm_pkg::ctl_stat_t          stat,
  input  logic [2:0]                  in_command,
  input  logic [15:0]                 in_batch,
  input  logic [15:0]                 in_cell,
  input  logic signed [31:0]          in_fitness,
  input  logic [63:0]                 in_payload,
  input  logic                        in_flag,
  input  logic [klm_pkg::CNT_W-1:0]   capacity,
  input  logic                        out_ready,
  output logic                        out_valid,
  output logic                        out_entry_valid,
  output klm_pkg::entry_t             out_entry,
  output logic                        out_last,
  output logic [klm_pkg::CNT_W-1:0]   out_left_taken,
  output logic [klm_pkg::CNT_W-1:0]   out_right_taken,
  output logic [klm_pkg::CNT_W-1:0]   out_conflicts,
  output logic [klm_pkg::CNT_W-1:0]   out_shield_wins,
  output logic [klm_pkg::CNT_W-1:0]   out_dropped
);

  localparam int CW  = $clog2(LEDGER_DEPTH + 1);
  localparam int AW  = LEDGER_DEPTH > 1 ? $clog2(LEDGER_DEPTH) : 1;
  localparam int PCW = $clog2(PROTECT_DEPTH + 1);
  localparam int PAW = PROTECT_DEPTH > 1 ? $clog2(PROTECT_DEPTH) : 1;
  localparam int NW  = klm_pkg::CNT_W;

  // ledger stores (flops, one read address each per cycle)
  logic [31:0]        lkey [LEDGER_DEPTH];
  logic signed [31:0] lfit [LEDGER_DEPTH];
  logic [63:0]        lpay [LEDGER_DEPTH];
  logic [31:0]        rkey [LEDGER_DEPTH];
  logic signed [31:0] rfit [LEDGER_DEPTH];
  logic [63:0]        rpay [LEDGER_DEPTH];

  logic [CW-1:0]  lc, rc, oi, si;
  logic [PCW-1:0] lpc, rpc, p;
  logic           pa, pb, win_r;
  logic [NW-1:0]  kl, kr, nc, pw, nd, n;
  klm_pkg::entry_t pend;
  logic           pend_valid;

  logic [AW-1:0]  laddr, raddr;
  logic [16:0]    lp_rdata, rp_rdata;
  logic           ld_left, ld_right, ld_lp, ld_rp;
  logic           below_cap, push;
  logic           dec_right, dec_prot;
  klm_pkg::entry_t new_entry;

  assign ld_left  = cmd.load && (in_command == klm_pkg::CMD_LOAD_LEFT) &&
                    (lc != CW'(LEDGER_DEPTH));
  assign ld_right = cmd.load && (in_command == klm_pkg::CMD_LOAD_RIGHT) &&
                    (rc != CW'(LEDGER_DEPTH));
  assign ld_lp    = cmd.load && (in_command == klm_pkg::CMD_PROTECT_LEFT) &&
                    (lpc != PCW'(PROTECT_DEPTH));
  assign ld_rp    = cmd.load && (in_command == klm_pkg::CMD_PROTECT_RIGHT) &&
                    (rpc != PCW'(PROTECT_DEPTH));

  always_ff @(posedge clk) begin
    if (ld_left) begin
      lkey[lc[AW-1:0]] <= {in_batch, in_cell};
      lfit[lc[AW-1:0]] <= in_fitness;
      lpay[lc[AW-1:0]] <= in_payload;
    end
    if (ld_right) begin
      rkey[rc[AW-1:0]] <= {in_batch, in_cell};
      rfit[rc[AW-1:0]] <= in_fitness;
      rpay[rc[AW-1:0]] <= in_payload;
    end
  end

  klm_ram #(.WIDTH(17), .DEPTH(PROTECT_DEPTH)) u_lprot (
    .clk  (clk),
    .we   (ld_lp),
    .waddr(lpc[PAW-1:0]),
    .wdata({in_flag, in_cell}),
    .raddr(p[PAW-1:0]),
    .rdata(lp_rdata)
  );

  klm_ram #(.WIDTH(17), .DEPTH(PROTECT_DEPTH)) u_rprot (
    .clk  (clk),
    .we   (ld_rp),
    .waddr(rpc[PAW-1:0]),
    .wdata({in_flag, in_cell}),
    .raddr(p[PAW-1:0]),
    .rdata(rp_rdata)
  );

  // left pass: outer index walks left, scan walks right; right pass swaps them
  assign laddr = cmd.phase_r ? si[AW-1:0] : oi[AW-1:0];
  assign raddr = cmd.phase_r ? oi[AW-1:0] : si[AW-1:0];

  assign stat.oi_end    = cmd.phase_r ? (oi == rc) : (oi == lc);
  assign stat.si_end    = cmd.phase_r ? (si == lc) : (si == rc);
  assign stat.key_match = lkey[laddr] == rkey[raddr];
  assign stat.p_end_l   = p == lpc;
  assign stat.p_end_r   = p == rpc;
  assign stat.hit_l     = lp_rdata[16] && (lp_rdata[15:0] == lkey[laddr][15:0]);
  assign stat.hit_r     = rp_rdata[16] && (rp_rdata[15:0] == lkey[laddr][15:0]);
  assign stat.out_free  = !out_valid || out_ready;
  assign below_cap      = n < ((capacity > NW'(klm_pkg::MAX_RESULTS)) ?
                               NW'(klm_pkg::MAX_RESULTS) : capacity);
  assign stat.emit_ok   = !below_cap || !pend_valid || stat.out_free;

  // contest: lower fitness wins (tie to left), one-sided protection overrides
  always_comb begin
    dec_right = rfit[raddr] < lfit[laddr];
    dec_prot  = pa != pb;
    if (dec_prot) begin
      dec_right = pb;
    end
  end

  always_comb begin
    if (win_r) begin
      new_entry = '{rkey[raddr][31:16], rkey[raddr][15:0], rfit[raddr], rpay[raddr], 1'b1};
    end else begin
      new_entry = '{lkey[laddr][31:16], lkey[laddr][15:0], lfit[laddr], lpay[laddr], 1'b0};
    end
  end

  assign push = (cmd.emit && below_cap && pend_valid) || cmd.finish;

  always_ff @(posedge clk) begin
    if (rst) begin
      lc <= '0;
      rc <= '0;
      lpc <= '0;
      rpc <= '0;
      pend_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.finish) begin
        lc <= '0;
        rc <= '0;
        lpc <= '0;
        rpc <= '0;
      end else begin
        if (ld_left)  lc  <= lc + CW'(1);
        if (ld_right) rc  <= rc + CW'(1);
        if (ld_lp)    lpc <= lpc + PCW'(1);
        if (ld_rp)    rpc <= rpc + PCW'(1);
      end
      if (cmd.run_clr || cmd.finish) begin
        pend_valid <= 1'b0;
      end else if (cmd.emit && below_cap) begin
        pend_valid <= 1'b1;
      end
      if (push) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.run_clr || cmd.oi_clr) oi <= '0;
    else if (cmd.oi_inc)           oi <= oi + CW'(1);
    if (cmd.si_clr)                si <= '0;
    else if (cmd.si_inc)           si <= si + CW'(1);
    if (cmd.p_clr)                 p  <= '0;
    else if (cmd.p_inc)            p  <= p + PCW'(1);
    if (cmd.pab_clr) begin
      pa <= 1'b0;
      pb <= 1'b0;
    end else begin
      if (cmd.set_pa) pa <= 1'b1;
      if (cmd.set_pb) pb <= 1'b1;
    end
    if (cmd.win_left)       win_r <= 1'b0;
    else if (cmd.win_right) win_r <= 1'b1;
    else if (cmd.win_decide) win_r <= dec_right;
    if (cmd.run_clr) begin
      kl <= '0;
      kr <= '0;
      nc <= '0;
      pw <= '0;
      nd <= '0;
      n  <= '0;
    end else begin
      if (cmd.nc_inc) nc <= nc + NW'(1);
      if (cmd.win_decide && dec_prot) pw <= pw + NW'(1);
      if (cmd.emit) begin
        if (win_r) kr <= kr + NW'(1);
        else       kl <= kl + NW'(1);
        if (below_cap) n  <= n + NW'(1);
        else           nd <= nd + NW'(1);
      end
    end
    if (cmd.emit && below_cap) begin
      pend <= new_entry;
    end
    if (push) begin
      out_entry_valid <= cmd.finish ? pend_valid : 1'b1;
      out_entry       <= (cmd.finish && !pend_valid) ? '0 : pend;
      out_last        <= cmd.finish;
      out_left_taken  <= cmd.finish ? kl : '0;
      out_right_taken <= cmd.finish ? kr : '0;
      out_conflicts   <= cmd.finish ? nc : '0;
      out_shield_wins <= cmd.finish ? pw : '0;
      out_dropped     <= cmd.finish ? nd : '0;
    end
  end

`ifndef SYNTHESIS
  a_push_free: assert property (@(posedge clk) disable iff (rst)
    push |-> (!out_valid || out_ready))
    else $error("result pushed over a held result");
  a_pend_counted: assert property (@(posedge clk) disable iff (rst)
    pend_valid |-> (n != '0))
    else $error("pending result with zero emit count");
  a_finish_clears: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |=> (lc == '0) && (rc == '0) && (lpc == '0) && (rpc == '0) && !pend_valid)
    else $error("stores not cleared after merge");
`endif

endmodule

[verif/klm_merge_checker.sv]
// Checker for the ledger merge: watches all channels, predicts merged entries, compares.
`timescale 1ns / 1ps
module klm_merge_checker
  import klm_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  input  logic         s_tready,
  input  logic [135:0] s_tdata,
  input  logic [2:0]   s_tuser,
  input  logic         m_tvalid,
  input  logic         m_tready,
  input  logic [159:0] m_tdata,
  input  logic [1:0]   m_tuser,
  input  logic         m_tlast,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [1:0]   paddr,
  input  logic [31:0]  pwdata,
  input  logic         pready,
  input  logic         run_done,
  output int           pending,
  output int           fail_count
);

  typedef struct packed {
    logic               entry_valid;
    logic [15:0]        batch;
    logic [15:0]        cell_idx;
    logic signed [31:0] fitness;
    logic [63:0]        payload;
    logic               from_right;
    logic               last;
    logic [5:0]         left_taken;
    logic [5:0]         right_taken;
    logic [5:0]         conflicts;
    logic [5:0]         shield_wins;
    logic [5:0]         dropped;
  } merged_entry_t;

  // ledger contents, key = {batch, cell}
  logic [31:0] lkey [LEDGER_DEPTH_DEF];
  logic [31:0] lfit [LEDGER_DEPTH_DEF];
  logic [63:0] lpay [LEDGER_DEPTH_DEF];
  logic [31:0] rkey [LEDGER_DEPTH_DEF];
  logic [31:0] rfit [LEDGER_DEPTH_DEF];
  logic [63:0] rpay [LEDGER_DEPTH_DEF];
  logic [16:0] lprot [PROTECT_DEPTH_DEF];
  logic [16:0] rprot [PROTECT_DEPTH_DEF];
  int lcnt, rcnt, lpcnt, rpcnt;
  logic [5:0] capacity;
  merged_entry_t merged_q[$];
  int mismatches;

  assign pending = merged_q.size();
  assign fail_count = mismatches;

  function automatic bit cell_protected(bit right_side, logic [15:0] cell_idx);
    int n;
    n = right_side ? rpcnt : lpcnt;
    for (int p = 0; p < n; p++) begin
      if (right_side ? (rprot[p][15:0] == cell_idx && rprot[p][16])
                     : (lprot[p][15:0] == cell_idx && lprot[p][16]))
        return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic merged_entry_t make_entry(logic [31:0] key, logic [31:0] fit,
                                               logic [63:0] pay, bit right_side);
    merged_entry_t e;
    e = '0;
    e.entry_valid = 1'b1;
    e.batch = key[31:16];
    e.cell_idx = key[15:0];
    e.fitness = fit;
    e.payload = pay;
    e.from_right = right_side;
    return e;
  endfunction

  task automatic merge_ledgers();
    merged_entry_t outs[$];
    int limit, kl, kr, nc, pw, nd, j;
    bit win_r, pa, pb, seen;
    limit = (capacity > MAX_RESULTS) ? MAX_RESULTS : capacity;
    kl = 0; kr = 0; nc = 0; pw = 0; nd = 0;
    for (int i = 0; i < lcnt; i++) begin
      win_r = 1'b0;
      for (j = 0; j < rcnt; j++)
        if (rkey[j] == lkey[i]) break;
      if (j < rcnt) begin
        pa = cell_protected(1'b0, lkey[i][15:0]);
        pb = cell_protected(1'b1, rkey[j][15:0]);
        nc++;
        if ($signed(rfit[j]) < $signed(lfit[i])) win_r = 1'b1;
        // one-sided protection overrides fitness
        if (pa && !pb) begin
          win_r = 1'b0;
          pw++;
        end else if (pb && !pa) begin
          win_r = 1'b1;
          pw++;
        end
      end
      if (win_r) kr++; else kl++;
      if (outs.size() < limit) begin
        if (win_r) outs.push_back(make_entry(rkey[j], rfit[j], rpay[j], 1'b1));
        else outs.push_back(make_entry(lkey[i], lfit[i], lpay[i], 1'b0));
      end else nd++;
    end
    for (int r = 0; r < rcnt; r++) begin
      seen = 1'b0;
      for (int i = 0; i < lcnt; i++)
        if (lkey[i] == rkey[r]) seen = 1'b1;
      if (!seen) begin
        kr++;
        if (outs.size() < limit) outs.push_back(make_entry(rkey[r], rfit[r], rpay[r], 1'b1));
        else nd++;
      end
    end
    if (outs.size() == 0) outs.push_back('0);
    outs[$].last = 1'b1;
    outs[$].left_taken = kl[5:0];
    outs[$].right_taken = kr[5:0];
    outs[$].conflicts = nc[5:0];
    outs[$].shield_wins = pw[5:0];
    outs[$].dropped = nd[5:0];
    foreach (outs[k]) merged_q.push_back(outs[k]);
    lcnt = 0; rcnt = 0; lpcnt = 0; rpcnt = 0;
  endtask

  task automatic take_request(logic [2:0] cmd, logic [135:0] d);
    case (cmd)
      CMD_LOAD_LEFT: if (lcnt < LEDGER_DEPTH_DEF) begin
        lkey[lcnt] = {d[15:0], d[31:16]};
        lfit[lcnt] = d[63:32];
        lpay[lcnt] = d[127:64];
        lcnt++;
      end
      CMD_LOAD_RIGHT: if (rcnt < LEDGER_DEPTH_DEF) begin
        rkey[rcnt] = {d[15:0], d[31:16]};
        rfit[rcnt] = d[63:32];
        rpay[rcnt] = d[127:64];
        rcnt++;
      end
      CMD_PROTECT_LEFT: if (lpcnt < PROTECT_DEPTH_DEF) begin
        lprot[lpcnt] = {d[128], d[31:16]};
        lpcnt++;
      end
      CMD_PROTECT_RIGHT: if (rpcnt < PROTECT_DEPTH_DEF) begin
        rprot[rpcnt] = {d[128], d[31:16]};
        rpcnt++;
      end
      CMD_MERGE: merge_ledgers();
      default: ;
    endcase
  endtask

  task automatic check_result();
    merged_entry_t got, want;
    got.entry_valid = m_tuser[0];
    got.from_right = m_tuser[1];
    got.last = m_tlast;
    got.batch = m_tdata[15:0];
    got.cell_idx = m_tdata[31:16];
    got.fitness = m_tdata[63:32];
    got.payload = m_tdata[127:64];
    got.left_taken = m_tdata[133:128];
    got.right_taken = m_tdata[139:134];
    got.conflicts = m_tdata[145:140];
    got.shield_wins = m_tdata[151:146];
    got.dropped = m_tdata[157:152];
    if (merged_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected result %p", got);
    end else begin
      want = merged_q.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10) $display("result differs\n  exp %p\n  act %p", want, got);
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      lcnt = 0; rcnt = 0; lpcnt = 0; rpcnt = 0;
      capacity = 6'd32;
      mismatches = 0;
    end else begin
      if (psel && penable && pwrite && pready && paddr == 2'(4 * REG_OUT_CAPACITY))
        capacity = pwdata[5:0];
      if (s_tvalid && s_tready) take_request(s_tuser, s_tdata);
      if (m_tvalid && m_tready) check_result();
    end
  end

  // expectations still queued at the end are failures
  always @(posedge run_done) mismatches += merged_q.size();

endmodule

[verif/tb_keyed_ledger_merge_with_protection_unit.sv]
// Testbench top for the ledger merge: stimulus, output stalls, watchdog and verdict.
`timescale 1ns / 1ps
module tb_keyed_ledger_merge_with_protection_unit;
  import klm_pkg::*;

  // commands the block must ignore
  localparam logic [2:0] CMD_SPARE_LO = 3'd5;
  localparam logic [2:0] CMD_SPARE_HI = 3'd7;
  localparam int STALL_LIMIT = 20000;  // watchdog limit; a long merge walk moves no request
  localparam int SETTLE_CYCLES = 40;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  // [15:0] batch, [31:16] cell_index, [63:32] fitness, [127:64] payload,
  // [128] protect_flag, [135:129] zero
  logic [135:0] s_tdata = '0;
  // [2:0] command
  logic [2:0]   s_tuser = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  // [15:0] out_batch, [31:16] out_cell_index, [63:32] out_fitness, [127:64] out_payload,
  // [133:128] left taken, [139:134] right taken, [145:140] conflicts,
  // [151:146] protection wins, [157:152] dropped, [159:158] zero
  logic [159:0] m_tdata;
  // [0] entry_valid, [1] from_right
  logic [1:0]   m_tuser;
  logic         m_tlast;
  logic         psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [1:0]   paddr = '0;
  logic [31:0]  pwdata = '0;
  logic [31:0]  prdata;
  logic         pready;
  logic         run_done = 1'b0;
  int           pending, fail_count;
  int           idle_cycles = 0;
  bit           src_gappy = 1'b1, sink_gappy = 1'b1;
  logic [31:0]  group_keys[$];

  always #6 clk = ~clk;

  keyed_ledger_merge_with_protection_unit dut (.*);

  klm_merge_checker chk (.*);

  // sink: random stall before each result, with stretches of none
  initial begin
    int stall;
    forever begin
      if ($urandom_range(0, 9) == 0) sink_gappy = ~sink_gappy;
      stall = sink_gappy ? $urandom_range(0, 15) : 0;
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
    end
  end

  // watchdog: cycles in which nothing moves on any channel
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || psel)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles == STALL_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic send(logic [2:0] cmd, logic [15:0] batch, logic [15:0] cell_idx,
                      logic [31:0] fit, logic [63:0] pay, logic flag);
    int gap;
    if ($urandom_range(0, 15) == 0) src_gappy = ~src_gappy;
    gap = src_gappy ? $urandom_range(0, 15) : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= {7'd0, flag, pay, fit, cell_idx, batch};
    do @(posedge clk); while (!s_tready);
  endtask

  // wait for the block to drain before touching the register
  task automatic settle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_capacity(logic [5:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 2'(4 * REG_OUT_CAPACITY);
    pwdata  <= {$urandom_range(0, 1) ? $urandom : 32'd0} & 32'hFFFF_FFC0 | value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // keys come from a small pool so that matches and duplicates are common
  function automatic logic [31:0] pick_key();
    logic [15:0] b, c;
    case ($urandom_range(0, 4))
      0: b = 16'h0000;
      1: b = 16'hFFFF;
      2: b = 16'($urandom);
      default: b = 16'd1;
    endcase
    case ($urandom_range(0, 5))
      0: c = 16'hFFFF;
      1: c = 16'($urandom);
      default: c = 16'($urandom_range(0, 4));
    endcase
    return {b, c};
  endfunction

  function automatic logic [31:0] pick_fitness();
    if ($urandom_range(0, 2) == 0) return $urandom;
    return 32'($signed($urandom_range(0, 6)) - 3);  // small values give ties
  endfunction

  // one well-formed load sequence ending in a merge, with some noise
  task automatic merge_group();
    int nl, nr, npl, npr;
    logic [31:0] k;
    nl  = ($urandom_range(0, 7) == 0) ? 18 : $urandom_range(0, 7);
    nr  = ($urandom_range(0, 7) == 0) ? 18 : $urandom_range(0, 7);
    npl = ($urandom_range(0, 9) == 0) ? 17 : $urandom_range(0, 3);
    npr = ($urandom_range(0, 9) == 0) ? 17 : $urandom_range(0, 3);
    group_keys.delete();
    for (int i = 0; i < nl; i++) begin
      k = pick_key();
      group_keys.push_back(k);
      send(CMD_LOAD_LEFT, k[31:16], k[15:0], pick_fitness(), {$urandom, $urandom}, 1'($urandom));
    end
    for (int i = 0; i < nr; i++) begin
      if (group_keys.size() > 0 && $urandom_range(0, 9) < 6)
        k = group_keys[$urandom_range(0, group_keys.size() - 1)];
      else
        k = pick_key();
      send(CMD_LOAD_RIGHT, k[31:16], k[15:0], pick_fitness(), {$urandom, $urandom}, 1'($urandom));
    end
    for (int i = 0; i < npl + npr; i++) begin
      k = (group_keys.size() > 0 && $urandom_range(0, 1)) ?
          group_keys[$urandom_range(0, group_keys.size() - 1)] : pick_key();
      send((i < npl) ? CMD_PROTECT_LEFT : CMD_PROTECT_RIGHT, 16'($urandom), k[15:0],
           $urandom, {$urandom, $urandom}, 1'($urandom_range(0, 3) != 0));
    end
    if ($urandom_range(0, 3) == 0)
      send(3'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI)), 16'($urandom), 16'($urandom),
           $urandom, {$urandom, $urandom}, 1'($urandom));
    send(CMD_MERGE, 16'($urandom), 16'($urandom), $urandom, {$urandom, $urandom},
         1'($urandom));
  endtask

  initial begin
    logic [5:0] caps[7];
    caps = '{6'd32, 6'd0, 6'd1, 6'd3, 6'd63, 6'd20, 6'd0};
    caps[6] = 6'($urandom_range(0, 63));
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    write_capacity(6'd32);

    // directed: empty merge, then each way a conflict can be decided
    send(CMD_MERGE, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, '1, 1'b1);
    send(CMD_LOAD_LEFT,  16'h0000, 16'h0000, 32'h7FFF_FFFF, 64'd0, 1'b0);
    send(CMD_LOAD_RIGHT, 16'h0000, 16'h0000, 32'h8000_0000, '1, 1'b0);     // right lower
    send(CMD_LOAD_LEFT,  16'hFFFF, 16'hFFFF, 32'd5, 64'h5555_5555_5555_5555, 1'b1);
    send(CMD_LOAD_RIGHT, 16'hFFFF, 16'hFFFF, 32'd5, 64'hAAAA_AAAA_AAAA_AAAA, 1'b1);  // tie
    send(CMD_LOAD_LEFT,  16'd1, 16'd7, 32'hFFFF_FFFF, 64'd1, 1'b0);
    send(CMD_LOAD_RIGHT, 16'd1, 16'd7, 32'd100, 64'd2, 1'b0);    // right protected only
    send(CMD_PROTECT_RIGHT, 16'd0, 16'd7, 32'd0, 64'd0, 1'b1);
    send(CMD_LOAD_LEFT,  16'd2, 16'd8, 32'd100, 64'd3, 1'b0);
    send(CMD_LOAD_RIGHT, 16'd2, 16'd8, 32'hFFFF_FF9C, 64'd4, 1'b0);  // left protected only
    send(CMD_PROTECT_LEFT, 16'hFFFF, 16'd8, 32'd0, 64'd0, 1'b1);
    send(CMD_LOAD_LEFT,  16'd3, 16'd9, 32'd10, 64'd5, 1'b0);
    send(CMD_LOAD_RIGHT, 16'd3, 16'd9, 32'd20, 64'd6, 1'b0);     // left flag clear
    send(CMD_PROTECT_LEFT, 16'd0, 16'd9, 32'd0, 64'd0, 1'b0);
    send(CMD_PROTECT_RIGHT, 16'd0, 16'd9, 32'd0, 64'd0, 1'b1);
    send(CMD_LOAD_LEFT,  16'd3, 16'd10, 32'd30, 64'd7, 1'b0);
    send(CMD_LOAD_RIGHT, 16'd3, 16'd10, 32'd20, 64'd8, 1'b0);    // both protected
    send(CMD_PROTECT_LEFT, 16'd0, 16'd10, 32'd0, 64'd0, 1'b1);
    send(CMD_PROTECT_RIGHT, 16'd0, 16'd10, 32'd0, 64'd0, 1'b1);
    send(CMD_LOAD_RIGHT, 16'd4, 16'd4, 32'd0, 64'd9, 1'b0);      // right only
    send(CMD_SPARE_LO, 16'd4, 16'd4, 32'd0, 64'd0, 1'b0);
    send(CMD_SPARE_HI, 16'd4, 16'd4, 32'd0, 64'd0, 1'b0);
    send(CMD_MERGE, 16'd0, 16'd0, 32'd0, 64'd0, 1'b0);

    // random phases, each under its own output capacity
    foreach (caps[p]) begin
      settle();
      write_capacity(caps[p]);
      merge_group();
    end

    settle();
    run_done <= 1'b1;
    @(posedge clk);
    @(posedge clk);
    if (fail_count == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule

[filelist.f]
src/klm_pkg.sv
src/klm_ram.sv
src/klm_ctrl.sv
src/klm_datapath.sv
src/keyed_ledger_merge_with_protection_unit.sv
verif/klm_merge_checker.sv
verif/tb_keyed_ledger_merge_with_protection_unit.sv
